[hdl/formation_follower_goto_controller_assert.svh]
// Assertion macros for the formation controller checker
`ifndef FORMATION_FOLLOWER_GOTO_CONTROLLER_ASSERT_SVH
`define FORMATION_FOLLOWER_GOTO_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FFGC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffgc assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define FFGC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffgc assertion failed");

`endif

[hdl/ffgc_pkg.sv]
// Shared types and constants of the formation goto controller
package ffgc_pkg;

	localparam int DATA_W = 36;  // position datapath, Q20 fraction
	localparam int ANG_W  = 30;  // angle datapath, Q24 fraction
	localparam int DEF_CORDIC_STAGES = 16;

	localparam logic signed [ANG_W-1:0] PI_Q24      = ANG_W'(52707179);
	localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = ANG_W'(26353589);
	localparam logic [29:0] K_Q30 = 30'd652032874;
	localparam logic signed [14:0] TURN_LIMIT = 15'sd12868;

	// Register word indices, matched against paddr[3:2]
	localparam logic [1:0] REG_OFFSET_X  = 2'd0;
	localparam logic [1:0] REG_OFFSET_Y  = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED = 2'd2;
	localparam logic [1:0] REG_DEADBAND  = 2'd3;

	localparam logic [ANG_W-1:0] ATAN_Q24 [24] = '{
		ANG_W'(13176795), ANG_W'(7778716), ANG_W'(4110060), ANG_W'(2086331),
		ANG_W'(1047214), ANG_W'(524117), ANG_W'(262123), ANG_W'(131069),
		ANG_W'(65536), ANG_W'(32768), ANG_W'(16384), ANG_W'(8192),
		ANG_W'(4096), ANG_W'(2048), ANG_W'(1024), ANG_W'(512),
		ANG_W'(256), ANG_W'(128), ANG_W'(64), ANG_W'(32),
		ANG_W'(16), ANG_W'(8), ANG_W'(4), ANG_W'(2)
	};

	// One item as it moves down the chain
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [ANG_W-1:0]  z;
		logic                     zero;
		logic signed [15:0]       lx;
		logic signed [15:0]       ly;
		logic signed [15:0]       fx;
		logic signed [15:0]       fy;
		logic signed [14:0]       fh;
	} item_t;

	// Stage handshake between cells
	typedef struct packed {
		logic en;
		logic valid;
	} stage_ctl_t;

endpackage

[hdl/ffgc_cordic_cell.sv]
// One CORDIC micro-rotation stage, rotation or vectoring mode
module ffgc_cordic_cell
	import ffgc_pkg::*;
#(
	parameter int STAGE = 0,
	parameter bit VECTOR = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_in,
	input  item_t      item_in,
	output logic       valid_out,
	output item_t      item_out
);

	logic signed [DATA_W-1:0] sh_x, sh_y;
	logic signed [ANG_W-1:0]  atan_c;
	logic                     dir_ccw;
	item_t                    nxt;
	logic                     valid_q;
	item_t                    item_q;

	// Compute the micro-rotation
	always_comb begin
		sh_x   = item_in.x >>> STAGE;
		sh_y   = item_in.y >>> STAGE;
		atan_c = $signed(ATAN_Q24[STAGE]);
		if (VECTOR) begin
			dir_ccw = item_in.y[DATA_W-1];
		end else begin
			dir_ccw = !item_in.z[ANG_W-1];
		end
		nxt = item_in;
		if (dir_ccw) begin
			nxt.x = item_in.x - sh_y;
			nxt.y = item_in.y + sh_x;
			nxt.z = VECTOR ? item_in.z + atan_c : item_in.z - atan_c;
		end else begin
			nxt.x = item_in.x + sh_y;
			nxt.y = item_in.y - sh_x;
			nxt.z = VECTOR ? item_in.z - atan_c : item_in.z + atan_c;
		end
		// vectoring with y >= 0 turns clockwise and adds the angle
		if (VECTOR) begin
			nxt.z = dir_ccw ? item_in.z - atan_c : item_in.z + atan_c;
		end
	end

	// Advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl_in.en) begin
			valid_q <= ctl_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.en) begin
			item_q <= nxt;
		end
	end

	assign valid_out = valid_q;
	assign item_out  = item_q;

endmodule

[hdl/ffgc_gain_cell.sv]
// Two-stage CORDIC gain correction, x and y times K in Q0.30
module ffgc_gain_cell
	import ffgc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_in,
	input  item_t      item_in,
	output logic       valid_out,
	output item_t      item_out
);

	localparam int LO_W  = 18;
	localparam int HI_W  = DATA_W - LO_W;
	localparam int SUM_W = DATA_W + 32;

	logic [LO_W+29:0]         lo_x, lo_y;
	logic [LO_W+29:0]         lo_x_s1, lo_y_s1;
	logic signed [HI_W-1:0]   hi_x_s1, hi_y_s1;
	item_t                    item_s1;
	logic                     valid_s1;
	logic signed [HI_W+30:0]  p_x, p_y;
	logic signed [SUM_W-1:0]  sum_x, sum_y;
	item_t                    nxt;
	logic                     valid_q;
	item_t                    item_q;

	// Low partial products
	assign lo_x = item_in.x[LO_W-1:0] * K_Q30;
	assign lo_y = item_in.y[LO_W-1:0] * K_Q30;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (ctl_in.en) begin
			valid_s1 <= ctl_in.valid;
			valid_q  <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.en) begin
			lo_x_s1 <= lo_x;
			lo_y_s1 <= lo_y;
			hi_x_s1 <= item_in.x[DATA_W-1:LO_W];
			hi_y_s1 <= item_in.y[DATA_W-1:LO_W];
			item_s1 <= item_in;
			item_q  <= nxt;
		end
	end

	// High partial products, sum, round half up and floor
	always_comb begin
		p_x   = hi_x_s1 * $signed({1'b0, K_Q30});
		p_y   = hi_y_s1 * $signed({1'b0, K_Q30});
		sum_x = (SUM_W'(p_x) <<< LO_W) + SUM_W'($signed({1'b0, lo_x_s1}))
			+ (SUM_W'(1) <<< 29);
		sum_y = (SUM_W'(p_y) <<< LO_W) + SUM_W'($signed({1'b0, lo_y_s1}))
			+ (SUM_W'(1) <<< 29);
		nxt   = item_s1;
		nxt.x = sum_x[DATA_W+29:30];
		nxt.y = sum_y[DATA_W+29:30];
	end

	assign valid_out = valid_q;
	assign item_out  = item_q;

endmodule

[hdl/formation_follower_goto_controller.sv]
// Top level: leader-follower formation goto controller on a chain of CORDIC cells
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid / in_stall    | leader and follower poses
//   out     | source    | out_valid / out_stall  | linear_speed, turn_rate
//   apb     | slave     | psel/penable/pready    | offset_x/y, max_speed, deadband
//
// One item enters every cycle while in_stall is low; its path runs through the input
// register, three CORDIC chains of CORDIC_STAGES cells, three two-stage gain cells
// and the output register. The whole chain advances together and holds while the output
// register has a transfer waiting under out_stall. Reset clears the valid bits and
// loads the register defaults.
module formation_follower_goto_controller
	import ffgc_pkg::*;
#(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] leader_x,
	input  logic signed [15:0] leader_y,
	input  logic signed [14:0] leader_heading,
	input  logic signed [15:0] follower_x,
	input  logic signed [15:0] follower_y,
	input  logic signed [14:0] follower_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        linear_speed,
	output logic signed [14:0] turn_rate,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int N = CORDIC_STAGES;

	logic signed [15:0] offset_x_q, offset_y_q;
	logic [14:0]        max_speed_q, deadband_q;
	logic               en;
	logic               in_v_q;
	logic signed [15:0] lx_q, ly_q, ofx_q, fx_q, fy_q, ofy_q;
	logic signed [14:0] lh_q, fh_q;
	item_t              c1_d [N+1];
	logic               c1_v [N+1];
	item_t              c2_d [N+1];
	logic               c2_v [N+1];
	item_t              c3_d [N+1];
	logic               c3_v [N+1];
	item_t              g1_d, g2_d, g3_d;
	logic               g1_v, g2_v, g3_v;
	item_t              err_c, vec_c;
	logic signed [16:0] dx, dy;
	logic signed [DATA_W-1:0] len_r;
	logic signed [ANG_W-1:0]  ang_r;
	logic signed [DATA_W-1:0] len_c;
	logic signed [ANG_W-1:0]  turn_c;
	logic [14:0]        speed_c;
	logic signed [14:0] turn_o;
	logic               out_v_q;
	logic [14:0]        speed_q;
	logic signed [14:0] turn_q;

	// Configuration registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q  <= -16'sd256;
			offset_y_q  <= -16'sd256;
			max_speed_q <= 15'd512;
			deadband_q  <= 15'd26;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_OFFSET_X:  offset_x_q  <= pwdata[15:0];
				REG_OFFSET_Y:  offset_y_q  <= pwdata[15:0];
				REG_MAX_SPEED: max_speed_q <= pwdata[14:0];
				REG_DEADBAND:  deadband_q  <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OFFSET_X:  prdata = {{16{offset_x_q[15]}}, offset_x_q};
			REG_OFFSET_Y:  prdata = {{16{offset_y_q[15]}}, offset_y_q};
			REG_MAX_SPEED: prdata = {17'd0, max_speed_q};
			REG_DEADBAND:  prdata = {17'd0, deadband_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Chain advance: hold everything while a result waits
	assign en       = !(out_v_q && out_stall);
	assign in_stall = out_v_q && out_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_q <= 1'b0;
		end else if (en) begin
			in_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lx_q  <= leader_x;
			ly_q  <= leader_y;
			lh_q  <= leader_heading;
			fx_q  <= follower_x;
			fy_q  <= follower_y;
			fh_q  <= follower_heading;
			ofx_q <= offset_x_q;
			ofy_q <= offset_y_q;
		end
	end

	// Offset into Q20, leader heading into Q24, fold to within half pi
	always_comb begin
		c1_d[0].x    = {{(DATA_W-28){ofx_q[15]}}, ofx_q, 12'd0};
		c1_d[0].y    = {{(DATA_W-28){ofy_q[15]}}, ofy_q, 12'd0};
		c1_d[0].z    = {{(ANG_W-27){lh_q[14]}}, lh_q, 12'd0};
		c1_d[0].zero = 1'b0;
		c1_d[0].lx   = lx_q;
		c1_d[0].ly   = ly_q;
		c1_d[0].fx   = fx_q;
		c1_d[0].fy   = fy_q;
		c1_d[0].fh   = fh_q;
		if (c1_d[0].z > HALF_PI_Q24) begin
			c1_d[0].z = c1_d[0].z - PI_Q24;
			c1_d[0].x = -c1_d[0].x;
			c1_d[0].y = -c1_d[0].y;
		end else if (c1_d[0].z < -HALF_PI_Q24) begin
			c1_d[0].z = c1_d[0].z + PI_Q24;
			c1_d[0].x = -c1_d[0].x;
			c1_d[0].y = -c1_d[0].y;
		end
	end
	assign c1_v[0] = in_v_q;

	// Rotate offset into the world frame
	for (genvar i = 0; i < N; i++) begin : g_chain1
		ffgc_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   ('{en: en, valid: c1_v[i]}),
			.item_in  (c1_d[i]),
			.valid_out(c1_v[i+1]),
			.item_out (c1_d[i+1])
		);
	end

	ffgc_gain_cell u_gain1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   ('{en: en, valid: c1_v[N]}),
		.item_in  (c1_d[N]),
		.valid_out(g1_v),
		.item_out (g1_d)
	);

	// World error to goal, follower heading negated, fold to within half pi
	always_comb begin
		dx       = {g1_d.lx[15], g1_d.lx} - {g1_d.fx[15], g1_d.fx};
		dy       = {g1_d.ly[15], g1_d.ly} - {g1_d.fy[15], g1_d.fy};
		err_c    = g1_d;
		err_c.x  = g1_d.x + {{(DATA_W-29){dx[16]}}, dx, 12'd0};
		err_c.y  = g1_d.y + {{(DATA_W-29){dy[16]}}, dy, 12'd0};
		err_c.z  = -{{(ANG_W-27){g1_d.fh[14]}}, g1_d.fh, 12'd0};
		if (err_c.z > HALF_PI_Q24) begin
			err_c.z = err_c.z - PI_Q24;
			err_c.x = -err_c.x;
			err_c.y = -err_c.y;
		end else if (err_c.z < -HALF_PI_Q24) begin
			err_c.z = err_c.z + PI_Q24;
			err_c.x = -err_c.x;
			err_c.y = -err_c.y;
		end
	end
	assign c2_d[0] = err_c;
	assign c2_v[0] = g1_v;

	// Rotate error into the follower body frame
	for (genvar i = 0; i < N; i++) begin : g_chain2
		ffgc_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   ('{en: en, valid: c2_v[i]}),
			.item_in  (c2_d[i]),
			.valid_out(c2_v[i+1]),
			.item_out (c2_d[i+1])
		);
	end

	ffgc_gain_cell u_gain2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   ('{en: en, valid: c2_v[N]}),
		.item_in  (c2_d[N]),
		.valid_out(g2_v),
		.item_out (g2_d)
	);

	// Vectoring entry: flag a null error, fold left half plane by pi
	always_comb begin
		vec_c      = g2_d;
		vec_c.zero = (g2_d.x == '0) && (g2_d.y == '0);
		vec_c.z    = '0;
		if (g2_d.x[DATA_W-1]) begin
			vec_c.z = g2_d.y[DATA_W-1] ? -PI_Q24 : PI_Q24;
			vec_c.x = -g2_d.x;
			vec_c.y = -g2_d.y;
		end
	end
	assign c3_d[0] = vec_c;
	assign c3_v[0] = g2_v;

	// Length and bearing of the body error
	for (genvar i = 0; i < N; i++) begin : g_chain3
		ffgc_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_in   ('{en: en, valid: c3_v[i]}),
			.item_in  (c3_d[i]),
			.valid_out(c3_v[i+1]),
			.item_out (c3_d[i+1])
		);
	end

	ffgc_gain_cell u_gain3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   ('{en: en, valid: c3_v[N]}),
		.item_in  (c3_d[N]),
		.valid_out(g3_v),
		.item_out (g3_d)
	);

	// Round to output formats, saturate, clamp, apply deadband
	always_comb begin
		len_r  = g3_d.zero ? '0 : g3_d.x;
		ang_r  = g3_d.zero ? '0 : g3_d.z;
		len_c  = (len_r + DATA_W'(2048)) >>> 12;
		turn_c = (ang_r + ANG_W'(2048)) >>> 12;
		if (len_c[DATA_W-1]) begin
			len_c = '0;
		end
		if (turn_c > ANG_W'(TURN_LIMIT)) begin
			turn_o = TURN_LIMIT;
		end else if (turn_c < -ANG_W'(TURN_LIMIT)) begin
			turn_o = -TURN_LIMIT;
		end else begin
			turn_o = turn_c[14:0];
		end
		if (len_c > $signed(DATA_W'(max_speed_q))) begin
			speed_c = max_speed_q;
		end else begin
			speed_c = len_c[14:0];
		end
		if (len_c < $signed(DATA_W'(deadband_q))) begin
			speed_c = '0;
			turn_o  = '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= g3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			speed_q <= speed_c;
			turn_q  <= turn_o;
		end
	end

	assign out_valid    = out_v_q;
	assign linear_speed = speed_q;
	assign turn_rate    = turn_q;

endmodule

[hdl/ffgc_checker.sv]
// Port-level checker for the formation goto controller, bound to the top level
`include "formation_follower_goto_controller_assert.svh"

module ffgc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [14:0] linear_speed,
	input logic [14:0] turn_rate
);

	// A waiting result stays offered
	`FFGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// A waiting result keeps its payload
	`FFGC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(linear_speed) && $stable(turn_rate))

	// A stalled input transfer stays offered
	`FFGC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid)

	// Input back-pressure only comes from a blocked result
	`FFGC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

	// Turn rate stays within plus or minus pi
	`FFGC_ASSERT_NOW(a_turn_range, out_valid, ($signed(turn_rate) <= 15'sd12868) && ($signed(turn_rate) >= -15'sd12868))

endmodule

bind formation_follower_goto_controller ffgc_checker u_ffgc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.linear_speed(linear_speed),
	.turn_rate   (turn_rate)
);
